/* sv/oal_pkg.sv */
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and constants for the offset agreement latch.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

   localparam int OFFSET_BITS  = 16;
   localparam int COUNT_BITS   = 32;
   localparam int SURV_BITS    = 8;
   localparam int RUN_BITS     = 8;
   localparam int EMPTY_BITS   = 16;
   localparam int CSR_IDX_BITS = 4;
   localparam int CSR_DATA_BITS = 16;
   localparam int EV_COUNT     = 8;

   // Event counter slots.
   localparam int EV_SEEN        = 0;
   localparam int EV_AMBIG       = 1;
   localparam int EV_EMPTY       = 2;
   localparam int EV_UNVERIFIED  = 3;
   localparam int EV_UNCOMPARED  = 4;
   localparam int EV_AGREE       = 5;
   localparam int EV_DISAGREE    = 6;
   localparam int EV_PREDISAGREE = 7;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_LATCH_RUN  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_ABSENT_RUN = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      ST_SEARCHING = 2'd0,
      ST_LATCHED   = 2'd1,
      ST_AMBIGUOUS = 2'd2,
      ST_ABSENT    = 2'd3
   } status_type;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [EV_COUNT-1:0]   event_type;

   typedef struct packed {
      logic [SURV_BITS-1:0]   survivor_count;
      logic                   was_compared;
      logic [OFFSET_BITS-1:0] cand_offset;
      logic                   bytes_matched;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]             latch_status;
      logic [OFFSET_BITS-1:0] held_offset;
      logic [RUN_BITS-1:0]    run_length;
      count_type              seen_total;
      count_type              ambiguous_total;
      count_type              empty_total;
      count_type              unverified_total;
      count_type              uncompared_total;
      count_type              agree_total;
      count_type              disagree_total;
      count_type              pre_disagree_total;
   } rsp_payload_type;

   typedef struct packed {
      status_type             status;
      logic [OFFSET_BITS-1:0] offset;
      logic [RUN_BITS-1:0]    run;
      logic [EMPTY_BITS-1:0]  empty_run;
   } state_type;

   typedef struct packed {
      logic [RUN_BITS-1:0]   latch_run_needed;
      logic [EMPTY_BITS-1:0] absent_run_needed;
   } cfg_type;

endpackage

`default_nettype wire

/* sv/oal_if.sv */
// ----------------------------------------------------------------------------
// oal_if
// Channel interfaces for observations, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface oal_req_if
   import oal_pkg::*;
   ;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface oal_rsp_if
   import oal_pkg::*;
   ;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface oal_csr_if
   import oal_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  reg_index;
   logic [CSR_DATA_BITS-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

/* sv/offset_agreement_latch_top.sv */
// ----------------------------------------------------------------------------
// offset_agreement_latch_top
// Consensus latch over a stream of search observations.
// ----------------------------------------------------------------------------
// Each transfer on the request channel is one observation and produces exactly
// one transfer on the response channel, carrying the latch status, the held
// offset, the agreement run and eight saturating event totals as they stand
// after that observation. The block takes one observation per clock cycle:
// the whole update is a single level of compare and increment logic between
// the state registers and the response register, so a response is valid in the
// next cycle and a new request is accepted in the same cycle that the previous
// response is transferred. Requests stall only while a response is held back by
// the sink. The two thresholds (latch run, index 0; absent run, index 1) are
// written on the register channel, which is always ready; writes to other indexes
// are accepted and ignored. Write them only while no response is outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module offset_agreement_latch_top
   import oal_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   oal_req_if.sink   req_chan,
   oal_rsp_if.source rsp_chan,
   oal_csr_if.sink   csr_chan
);

   // The state registers double as the response payload: they only change on
   // a request transfer, and a request is only taken when the previous
   // response has gone or is going out in the same cycle.
   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_xfer;
   event_type events;
   event_type bump;
   count_type totals [EV_COUNT];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   oal_core u_core (
      .state     (state_ff),
      .obs       (req_chan.payload),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .events    (events)
   );

   assign bump = req_xfer ? events : '0;

   oal_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .bump   (bump),
      .totals (totals)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_LATCH_RUN:  cfg_in.latch_run_needed  = csr_chan.wr_data[RUN_BITS-1:0];
            CSR_ABSENT_RUN: cfg_in.absent_run_needed = csr_chan.wr_data[EMPTY_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.status    <= ST_SEARCHING;
         state_ff.offset    <= '0;
         state_ff.run       <= '0;
         state_ff.empty_run <= '0;
         cfg_ff.latch_run_needed  <= RUN_BITS'(3);
         cfg_ff.absent_run_needed <= EMPTY_BITS'(64);
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload straight from the state and counter registers.
   assign rsp_chan.valid                      = rsp_valid_ff;
   assign rsp_chan.payload.latch_status       = state_ff.status;
   assign rsp_chan.payload.held_offset        = state_ff.offset;
   assign rsp_chan.payload.run_length         = state_ff.run;
   assign rsp_chan.payload.seen_total         = totals[EV_SEEN];
   assign rsp_chan.payload.ambiguous_total    = totals[EV_AMBIG];
   assign rsp_chan.payload.empty_total        = totals[EV_EMPTY];
   assign rsp_chan.payload.unverified_total   = totals[EV_UNVERIFIED];
   assign rsp_chan.payload.uncompared_total   = totals[EV_UNCOMPARED];
   assign rsp_chan.payload.agree_total        = totals[EV_AGREE];
   assign rsp_chan.payload.disagree_total     = totals[EV_DISAGREE];
   assign rsp_chan.payload.pre_disagree_total = totals[EV_PREDISAGREE];

endmodule

`default_nettype wire

/* sv/oal_core.sv */
// ----------------------------------------------------------------------------
// oal_core
// Next-state logic of the agreement latch for one observation.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_core
   import oal_pkg::*;
(
   input  state_type       state,
   input  req_payload_type obs,
   input  cfg_type         cfg,
   output state_type       state_nxt,
   output event_type       events
);

   logic                  multi;
   logic                  single;
   logic                  off_differs;
   logic [RUN_BITS-1:0]   run_base;
   logic [RUN_BITS-1:0]   run_inc;
   logic [EMPTY_BITS-1:0] empty_inc;

   always_comb begin
      multi       = obs.survivor_count > SURV_BITS'(1);
      single      = obs.survivor_count == SURV_BITS'(1);
      off_differs = obs.cand_offset != state.offset;
      run_base    = (state.run != '0 && off_differs) ? '0 : state.run;
      run_inc     = (run_base == '1) ? run_base : run_base + RUN_BITS'(1);
      empty_inc   = (state.empty_run == '1) ? state.empty_run
                                            : state.empty_run + EMPTY_BITS'(1);
   end

   always_comb begin
      state_nxt       = state;
      events          = '0;
      events[EV_SEEN] = 1'b1;
      if (multi) begin
         events[EV_AMBIG] = 1'b1;
         state_nxt.status = ST_AMBIGUOUS;
         state_nxt.run    = '0;
      end else if (state.status == ST_AMBIGUOUS || state.status == ST_ABSENT) begin
         // Ambiguous and absent states with at most one survivor: only the seen counter moves.
      end else if (!single) begin
         events[EV_EMPTY] = 1'b1;
         if (state.status == ST_LATCHED) begin
            events[EV_UNVERIFIED] = 1'b1;
         end else begin
            state_nxt.run       = '0;
            state_nxt.empty_run = empty_inc;
            if (empty_inc >= cfg.absent_run_needed) begin
               state_nxt.status = ST_ABSENT;
            end
         end
      end else begin
         state_nxt.empty_run = '0;
         if (!obs.was_compared) begin
            events[EV_UNCOMPARED] = 1'b1;
         end else if (state.status == ST_LATCHED) begin
            if (off_differs) begin
               events[EV_AMBIG] = 1'b1;
               state_nxt.status = ST_AMBIGUOUS;
               state_nxt.run    = '0;
            end else if (obs.bytes_matched) begin
               events[EV_AGREE] = 1'b1;
            end else begin
               events[EV_DISAGREE] = 1'b1;
            end
         end else if (!obs.bytes_matched) begin
            events[EV_PREDISAGREE] = 1'b1;
            state_nxt.run          = '0;
         end else begin
            state_nxt.offset = obs.cand_offset;
            state_nxt.run    = run_inc;
            if (run_inc >= cfg.latch_run_needed) begin
               state_nxt.status = ST_LATCHED;
            end
         end
      end
   end

endmodule

`default_nettype wire

/* sv/oal_counters.sv */
// ----------------------------------------------------------------------------
// oal_counters
// Eight saturating event counters, bumped by a strobe vector.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_counters
   import oal_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  event_type bump,
   output count_type totals [EV_COUNT]
);

   count_type count_ff [EV_COUNT];
   count_type count_in [EV_COUNT];

   always_comb begin
      for (int i = 0; i < EV_COUNT; i++) begin
         count_in[i] = count_ff[i];
         if (bump[i] && count_ff[i] != '1) begin
            count_in[i] = count_ff[i] + COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < EV_COUNT; i++) begin
         if (reset) begin
            count_ff[i] <= '0;
         end else begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   assign totals = count_ff;

endmodule

`default_nettype wire
